// File: rtl/ssd_pkg.sv
package ssd_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int OUT_WIDTH       = 50;
	// register stages inside ssd_mul
	localparam int MUL_LAT         = 2;

endpackage

// File: rtl/ssd_dly.sv
module ssd_dly #(
	parameter int W     = ssd_pkg::COORD_WIDTH_DEF,
	parameter int DEPTH = ssd_pkg::MUL_LAT
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	output logic [W-1:0] out_data
);

	logic         vld_s [DEPTH];
	logic [W-1:0] dat_s [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) vld_s[k] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < DEPTH; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		dat_s[0] <= in_data;
		for (int k = 1; k < DEPTH; k++) dat_s[k] <= dat_s[k-1];
	end

	assign out_valid = vld_s[DEPTH-1];
	assign out_data  = dat_s[DEPTH-1];

endmodule

// File: rtl/ssd_mul.sv
module ssd_mul #(
	parameter int WA = ssd_pkg::COORD_WIDTH_DEF,
	parameter int WB = ssd_pkg::COORD_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic signed [WA-1:0]  a,
	input  logic signed [WB-1:0]  b,
	output logic signed [WA+WB-1:0] p
);

	localparam int LA = WA / 2;
	localparam int HA = WA - LA;
	localparam int LB = WB / 2;
	localparam int HB = WB - LB;
	localparam int PW = WA + WB;

	logic signed [LA:0]   a_lo;
	logic signed [HA-1:0] a_hi;
	logic signed [LB:0]   b_lo;
	logic signed [HB-1:0] b_hi;

	logic signed [LA+LB+1:0]  ll_s1;
	logic signed [HA+LB:0]    hl_s1;
	logic signed [LA+HB:0]    lh_s1;
	logic signed [HA+HB-1:0]  hh_s1;
	logic signed [PW-1:0]     p_s2;

	// low halves are unsigned magnitudes, high halves carry the sign
	assign a_lo = $signed({1'b0, a[LA-1:0]});
	assign a_hi = a[WA-1:LA];
	assign b_lo = $signed({1'b0, b[LB-1:0]});
	assign b_hi = b[WB-1:LB];

	always_ff @(posedge clk) begin
		ll_s1 <= a_lo * b_lo;
		hl_s1 <= a_hi * b_lo;
		lh_s1 <= a_lo * b_hi;
		hh_s1 <= a_hi * b_hi;
		p_s2  <= (PW'(hh_s1) <<< (LA + LB)) + (PW'(hl_s1) <<< LA)
		       + (PW'(lh_s1) <<< LB) + PW'(ll_s1);
	end

	assign p = p_s2;

endmodule

// File: rtl/ssd_div.sv
module ssd_div #(
	parameter int W = ssd_pkg::COORD_WIDTH_DEF,
	parameter int F = ssd_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic signed [W-1:0] num,
	input  logic signed [W-1:0] den,
	output logic        [F:0]   q
);

	// clamp01(num/den): entry stage, then one restoring step per quotient bit
	logic         nonpos;
	logic         ge;
	logic         in_rng;

	logic [W-2:0] rem_s [F+1];
	logic [W-2:0] den_s [F+1];
	logic [F-1:0] quo_s [F+1];
	logic         np_s  [F+1];
	logic         ge_s  [F+1];

	assign nonpos = num[W-1] || (num == '0);
	assign ge     = (num >= den);
	assign in_rng = !nonpos && !ge;

	always_ff @(posedge clk) begin
		rem_s[0] <= in_rng ? num[W-2:0] : '0;
		den_s[0] <= den[W-2:0];
		quo_s[0] <= '0;
		np_s[0]  <= nonpos;
		ge_s[0]  <= ge;
	end

	for (genvar k = 1; k <= F; k++) begin : g_step
		logic [W-1:0] sh;
		logic [W:0]   dif;
		logic         take;

		assign sh   = {rem_s[k-1], 1'b0};
		assign dif  = {1'b0, sh} - {2'b00, den_s[k-1]};
		assign take = !dif[W];

		always_ff @(posedge clk) begin
			rem_s[k] <= take ? dif[W-2:0] : sh[W-2:0];
			den_s[k] <= den_s[k-1];
			quo_s[k] <= {quo_s[k-1][F-2:0], take};
			np_s[k]  <= np_s[k-1];
			ge_s[k]  <= ge_s[k-1];
		end
	end

	always_comb begin
		if (np_s[F])      q = '0;
		else if (ge_s[F]) q = {1'b1, {F{1'b0}}};
		else              q = {1'b0, quo_s[F]};
	end

endmodule

// File: rtl/segment_segment_distance_sq.sv
// Squared distance between the closest points of two 3-D segments.
// Input: drive the twelve signed coordinates and raise start for one cycle;
// a beat is taken at each clock edge where start is high and busy is low.
// busy is always low, so a new pair can be taken every cycle.
// Output: distance_squared is valid for exactly one cycle while done is high;
// the receiver cannot hold it off, and there is nothing to stall.
// Ordering: one result per accepted beat, in order.
// The pipeline holds two chained quotient dividers (one bit a stage,
// PARAM_FRAC_BITS + 1 stages each) plus three two-stage split multipliers
// and the setup, sum and output registers.
// Throughput: one pair per clock, fully pipelined.
// Reset: arst_n clears all valid bits at once; items in flight are dropped.
// Result is an unsigned integer (2F fraction bits dropped), saturated to all ones on overflow.
module segment_segment_distance_sq #(
	parameter int COORD_WIDTH     = ssd_pkg::COORD_WIDTH_DEF,
	parameter int PARAM_FRAC_BITS = ssd_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] seg_a_start_x,
	input  logic signed [COORD_WIDTH-1:0] seg_a_start_y,
	input  logic signed [COORD_WIDTH-1:0] seg_a_start_z,
	input  logic signed [COORD_WIDTH-1:0] seg_a_end_x,
	input  logic signed [COORD_WIDTH-1:0] seg_a_end_y,
	input  logic signed [COORD_WIDTH-1:0] seg_a_end_z,
	input  logic signed [COORD_WIDTH-1:0] seg_b_start_x,
	input  logic signed [COORD_WIDTH-1:0] seg_b_start_y,
	input  logic signed [COORD_WIDTH-1:0] seg_b_start_z,
	input  logic signed [COORD_WIDTH-1:0] seg_b_end_x,
	input  logic signed [COORD_WIDTH-1:0] seg_b_end_y,
	input  logic signed [COORD_WIDTH-1:0] seg_b_end_z,
	output logic                          done,
	output logic [ssd_pkg::OUT_WIDTH-1:0] distance_squared
);

	localparam int CW      = COORD_WIDTH;
	localparam int F       = PARAM_FRAC_BITS;
	localparam int OW      = ssd_pkg::OUT_WIDTH;
	localparam int DW      = CW + 1;
	localparam int PW      = 2 * DW;
	localparam int DOTW    = PW + 2;
	localparam int MW      = 2 * DOTW;
	localparam int N1W     = MW + 1;
	localparam int SW      = F + 2;
	localparam int N2W     = DOTW + F + 3;
	localparam int N3W     = DOTW + 1;
	localparam int CCW     = DW + F + 3;
	localparam int SQW     = 2 * CCW;
	localparam int SUMW    = SQW + 2;
	localparam int SHW     = SUMW - 2 * F;
	localparam int XW      = (SHW > OW) ? SHW : OW + 1;
	localparam int DIV_LAT = F + 1;
	localparam int VECW    = 9 * DW;
	localparam int CTXA    = 5 * DOTW + VECW;
	localparam int CTXB    = CTXA + 2;
	localparam int CTXC    = CTXB + F + 1;
	localparam int CTXD    = 4 + F + 1 + VECW;

	logic [2:0][CW-1:0] pa, qa, pb, qb;

	assign busy = 1'b0;
	assign pa = {seg_a_start_z, seg_a_start_y, seg_a_start_x};
	assign qa = {seg_a_end_z,   seg_a_end_y,   seg_a_end_x};
	assign pb = {seg_b_start_z, seg_b_start_y, seg_b_start_x};
	assign qb = {seg_b_end_z,   seg_b_end_y,   seg_b_end_x};

	// ---- stages 1..3: direction vectors, element products, dot products
	logic               v_s1, v_s2, v_s3;
	logic [2:0][DW-1:0] d1_s1, d2_s1, rv_s1;
	logic [2:0][DW-1:0] d1_s2, d2_s2, rv_s2;
	logic [2:0][DW-1:0] d1_s3, d2_s3, rv_s3;
	logic [2:0][PW-1:0] aa_s2, ee_s2, ff_s2, cc_s2, bb_s2;
	logic signed [DOTW-1:0] a_s3, e_s3, f_s3, c_s3, b_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			d1_s1[i] <= DW'($signed(qa[i])) - DW'($signed(pa[i]));
			d2_s1[i] <= DW'($signed(qb[i])) - DW'($signed(pb[i]));
			rv_s1[i] <= DW'($signed(pa[i])) - DW'($signed(pb[i]));
			aa_s2[i] <= $signed(d1_s1[i]) * $signed(d1_s1[i]);
			ee_s2[i] <= $signed(d2_s1[i]) * $signed(d2_s1[i]);
			ff_s2[i] <= $signed(d2_s1[i]) * $signed(rv_s1[i]);
			cc_s2[i] <= $signed(d1_s1[i]) * $signed(rv_s1[i]);
			bb_s2[i] <= $signed(d1_s1[i]) * $signed(d2_s1[i]);
		end
		d1_s2 <= d1_s1;
		d2_s2 <= d2_s1;
		rv_s2 <= rv_s1;
		a_s3  <= DOTW'($signed(aa_s2[0])) + DOTW'($signed(aa_s2[1]))
		       + DOTW'($signed(aa_s2[2]));
		e_s3  <= DOTW'($signed(ee_s2[0])) + DOTW'($signed(ee_s2[1]))
		       + DOTW'($signed(ee_s2[2]));
		f_s3  <= DOTW'($signed(ff_s2[0])) + DOTW'($signed(ff_s2[1]))
		       + DOTW'($signed(ff_s2[2]));
		c_s3  <= DOTW'($signed(cc_s2[0])) + DOTW'($signed(cc_s2[1]))
		       + DOTW'($signed(cc_s2[2]));
		b_s3  <= DOTW'($signed(bb_s2[0])) + DOTW'($signed(bb_s2[1]))
		       + DOTW'($signed(bb_s2[2]));
		d1_s3 <= d1_s2;
		d2_s3 <= d2_s2;
		rv_s3 <= rv_s2;
	end

	// ---- cross products for the general-case numerator and denominator
	logic signed [MW-1:0] ae_p, bb_p, bf_p, ce_p;

	ssd_mul #(.WA(DOTW), .WB(DOTW)) u_mul_ae (.clk(clk), .a(a_s3), .b(e_s3), .p(ae_p));
	ssd_mul #(.WA(DOTW), .WB(DOTW)) u_mul_bb (.clk(clk), .a(b_s3), .b(b_s3), .p(bb_p));
	ssd_mul #(.WA(DOTW), .WB(DOTW)) u_mul_bf (.clk(clk), .a(b_s3), .b(f_s3), .p(bf_p));
	ssd_mul #(.WA(DOTW), .WB(DOTW)) u_mul_ce (.clk(clk), .a(c_s3), .b(e_s3), .p(ce_p));

	logic                   v_a;
	logic [CTXA-1:0]        ctxa;
	logic signed [DOTW-1:0] a_a, e_a, c_a;

	ssd_dly #(.W(CTXA), .DEPTH(ssd_pkg::MUL_LAT)) u_dly_a (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s3),
		.in_data({a_s3, e_s3, f_s3, c_s3, b_s3, d1_s3, d2_s3, rv_s3}),
		.out_valid(v_a), .out_data(ctxa)
	);
	// context layout: a, e, f, c, b, then the vectors
	assign a_a = ctxa[VECW + 4*DOTW +: DOTW];
	assign e_a = ctxa[VECW + 3*DOTW +: DOTW];
	assign c_a = ctxa[VECW + DOTW +: DOTW];

	// ---- stage 6: case split, pick the first quotient
	logic signed [N1W-1:0] denom, nums, num1, den1;
	logic                  az, ez, den_pos;
	logic                  v_s6;
	logic signed [N1W-1:0] num1_s6, den1_s6;
	logic [CTXB-1:0]       ctx_s6;

	always_comb begin
		az      = (a_a == '0);
		ez      = (e_a == '0);
		denom   = N1W'(ae_p) - N1W'(bb_p);
		nums    = N1W'(bf_p) - N1W'(ce_p);
		den_pos = !denom[N1W-1] && (denom != '0);
		if (az) begin
			num1 = '0;
			den1 = '0;
		end else if (ez) begin
			num1 = -N1W'(c_a);
			den1 = N1W'(a_a);
		end else if (den_pos) begin
			num1 = nums;
			den1 = denom;
		end else begin
			num1 = '0;
			den1 = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else         v_s6 <= v_a;
	end

	always_ff @(posedge clk) begin
		num1_s6 <= num1;
		den1_s6 <= den1;
		ctx_s6  <= {az, ez, ctxa};
	end

	logic [F:0]      sq1;
	logic            v_b;
	logic [CTXB-1:0] ctxb;

	ssd_div #(.W(N1W), .F(F)) u_div_s (.clk(clk), .num(num1_s6), .den(den1_s6), .q(sq1));

	ssd_dly #(.W(CTXB), .DEPTH(DIV_LAT)) u_dly_b (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s6), .in_data(ctx_s6),
		.out_valid(v_b), .out_data(ctxb)
	);

	// ---- stage 7: first s, then b*s
	logic                   v_s7;
	logic [F:0]             s1_s7;
	logic [CTXB-1:0]        ctx_s7;
	logic signed [DOTW-1:0] b_s7;
	logic signed [DOTW+SW-1:0] bs_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else         v_s7 <= v_b;
	end

	always_ff @(posedge clk) begin
		s1_s7  <= sq1;
		ctx_s7 <= ctxb;
	end

	assign b_s7 = ctx_s7[VECW +: DOTW];

	ssd_mul #(.WA(DOTW), .WB(SW)) u_mul_bs (
		.clk(clk), .a(b_s7), .b($signed({1'b0, s1_s7})), .p(bs_p)
	);

	logic                   v_c;
	logic [CTXC-1:0]        ctxc;
	logic                   az_c, ez_c;
	logic signed [DOTW-1:0] a_c, e_c, f_c, c_c, b_c;
	logic [VECW-1:0]        vec_c;
	logic [F:0]             s1_c;

	ssd_dly #(.W(CTXC), .DEPTH(ssd_pkg::MUL_LAT)) u_dly_c (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s7), .in_data({ctx_s7, s1_s7}),
		.out_valid(v_c), .out_data(ctxc)
	);
	assign {az_c, ez_c, a_c, e_c, f_c, c_c, b_c, vec_c, s1_c} = ctxc;

	// ---- stage 8: t numerator, range tests, s re-clamp numerator
	logic signed [N2W-1:0] num2, den2;
	logic signed [N3W-1:0] num3;
	logic                  tneg, tbig;
	logic                  v_s8;
	logic signed [N2W-1:0] num2_s8, den2_s8;
	logic signed [N3W-1:0] num3_s8, den3_s8;
	logic [CTXD-1:0]       ctx_s8;

	always_comb begin
		num2 = N2W'(bs_p) + (N2W'(f_c) <<< F);
		den2 = N2W'(e_c) <<< F;
		tneg = num2[N2W-1];
		tbig = (num2 > den2);
		if (tneg) num3 = -N3W'(c_c);
		else      num3 = N3W'(b_c) - N3W'(c_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else         v_s8 <= v_c;
	end

	always_ff @(posedge clk) begin
		num2_s8 <= num2;
		den2_s8 <= den2;
		num3_s8 <= num3;
		den3_s8 <= N3W'(a_c);
		ctx_s8  <= {az_c, ez_c, tneg, tbig, s1_c, vec_c};
	end

	logic [F:0]      tq, sq3;
	logic            v_d;
	logic [CTXD-1:0] ctxd;
	logic            az_d, ez_d, tneg_d, tbig_d;
	logic [F:0]      s1_d;
	logic [VECW-1:0] vec_d;

	ssd_div #(.W(N2W), .F(F)) u_div_t (.clk(clk), .num(num2_s8), .den(den2_s8), .q(tq));
	ssd_div #(.W(N3W), .F(F)) u_div_r (.clk(clk), .num(num3_s8), .den(den3_s8), .q(sq3));

	ssd_dly #(.W(CTXD), .DEPTH(DIV_LAT)) u_dly_d (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s8), .in_data(ctx_s8),
		.out_valid(v_d), .out_data(ctxd)
	);
	assign {az_d, ez_d, tneg_d, tbig_d, s1_d, vec_d} = ctxd;

	// ---- stage 9: final s and t; t out of range takes the re-clamped s
	logic               v_s9;
	logic [F:0]         s_s9, t_s9;
	logic [2:0][DW-1:0] d1_s9, d2_s9, rv_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else         v_s9 <= v_d;
	end

	always_ff @(posedge clk) begin
		s_s9 <= (!az_d && !ez_d && (tneg_d || tbig_d)) ? sq3 : s1_d;
		t_s9 <= ez_d ? '0 : tq;
		{d1_s9, d2_s9, rv_s9} <= vec_d;
	end

	// ---- stages 10, 11: closest-point offset per axis
	logic                  v_s10, v_s11, v_s12, v_s13;
	logic [2:0][DW+SW-1:0] p1_s10, p2_s10;
	logic [2:0][DW-1:0]    rv_s10;
	logic signed [CCW-1:0] cc_s11 [3];
	logic signed [SQW-1:0] sq_p [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			done  <= 1'b0;
		end else begin
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			done  <= v_s13;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			p1_s10[i] <= $signed(d1_s9[i]) * $signed({1'b0, s_s9});
			p2_s10[i] <= $signed(d2_s9[i]) * $signed({1'b0, t_s9});
			cc_s11[i] <= (CCW'($signed(rv_s10[i])) <<< F) + CCW'($signed(p1_s10[i]))
			           - CCW'($signed(p2_s10[i]));
		end
		rv_s10 <= rv_s9;
	end

	for (genvar i = 0; i < 3; i++) begin : g_sq
		ssd_mul #(.WA(CCW), .WB(CCW)) u_mul_sq (
			.clk(clk), .a(cc_s11[i]), .b(cc_s11[i]), .p(sq_p[i])
		);
	end

	// ---- output: sum of squares, drop 2F fraction bits, saturate
	logic [SUMW-1:0] sum_c;
	logic [XW-1:0]   xs;
	logic            big;

	always_comb begin
		sum_c = SUMW'(sq_p[0]) + SUMW'(sq_p[1]) + SUMW'(sq_p[2]);
		xs    = XW'(sum_c[SUMW-1:2*F]);
		big   = |xs[XW-1:OW];
	end

	always_ff @(posedge clk) begin
		distance_squared <= big ? '1 : xs[OW-1:0];
	end

endmodule

// File: tb/tb_segment_segment_distance_sq.sv
module tb_segment_segment_distance_sq;

	localparam int CW = ssd_pkg::COORD_WIDTH_DEF;
	localparam int FB = ssd_pkg::FRAC_BITS_DEF;
	localparam int OW = ssd_pkg::OUT_WIDTH;
	localparam int LAT = 2 * FB + 18;

	typedef logic signed [191:0] wide_t;
	typedef logic signed [CW-1:0] coord_t;
	typedef coord_t seg_pair_t [12];

	// exact squared distance, same fixed-point steps as the block
	function automatic wide_t frac_clamp(wide_t num, wide_t den);
		wide_t one;
		one = wide_t'(1) <<< FB;
		if (num <= 0) return 0;
		if (num >= den) return one;
		return (num <<< FB) / den;
	endfunction

	function automatic logic [OW-1:0] closest_dist_sq(seg_pair_t p);
		wide_t d1[3], d2[3], rv[3];
		wide_t a, e, f, c, b, s, t, one, den, num, esc, cc, sum, pa, qa, pb, qb;
		one = wide_t'(1) <<< FB;
		for (int i = 0; i < 3; i++) begin
			pa = p[i]; qa = p[3+i]; pb = p[6+i]; qb = p[9+i];
			d1[i] = qa - pa;
			d2[i] = qb - pb;
			rv[i] = pa - pb;
		end
		a = d1[0]*d1[0] + d1[1]*d1[1] + d1[2]*d1[2];
		e = d2[0]*d2[0] + d2[1]*d2[1] + d2[2]*d2[2];
		f = d2[0]*rv[0] + d2[1]*rv[1] + d2[2]*rv[2];
		if (a == 0) begin
			s = 0;
			t = (e == 0) ? wide_t'(0) : frac_clamp(f, e);
		end else begin
			c = d1[0]*rv[0] + d1[1]*rv[1] + d1[2]*rv[2];
			if (e == 0) begin
				t = 0;
				s = frac_clamp(-c, a);
			end else begin
				b = d1[0]*d2[0] + d1[1]*d2[1] + d1[2]*d2[2];
				den = a*e - b*b;
				s = (den > 0) ? frac_clamp(b*f - c*e, den) : wide_t'(0);
				num = b*s + f*one;
				esc = e*one;
				if (num < 0) begin
					t = 0;
					s = frac_clamp(-c, a);
				end else if (num > esc) begin
					t = one;
					s = frac_clamp(b - c, a);
				end else begin
					t = frac_clamp(num, esc);
				end
			end
		end
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			cc = rv[i]*one + d1[i]*s - d2[i]*t;
			sum = sum + cc*cc;
		end
		sum = sum >>> (2*FB);
		if (sum >= (wide_t'(1) <<< OW)) return '1;
		return sum[OW-1:0];
	endfunction

	class dist_scoreboard;
		logic [OW-1:0] pending[$];
		int errors = 0;
		int n_in = 0;
		int n_out = 0;

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		function void note_pair(seg_pair_t p);
			pending = {pending, closest_dist_sq(p)};
			n_in++;
		endfunction

		task check_dist(logic [OW-1:0] got);
			logic [OW-1:0] want;
			n_out++;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result %0d", got));
				return;
			end
			want = pending.pop_front();
			if (got !== want)
				report($sformatf("distance_squared got %0d want %0d", got, want));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy, done;
	logic [OW-1:0] distance_squared;
	seg_pair_t pts = '{default: '0};
	dist_scoreboard sb = new();

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	segment_segment_distance_sq uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.seg_a_start_x(pts[0]), .seg_a_start_y(pts[1]), .seg_a_start_z(pts[2]),
		.seg_a_end_x(pts[3]), .seg_a_end_y(pts[4]), .seg_a_end_z(pts[5]),
		.seg_b_start_x(pts[6]), .seg_b_start_y(pts[7]), .seg_b_start_z(pts[8]),
		.seg_b_end_x(pts[9]), .seg_b_end_y(pts[10]), .seg_b_end_z(pts[11]),
		.done(done), .distance_squared(distance_squared)
	);

	always @(posedge clk) begin
		if (arst_n && start && !busy) sb.note_pair(pts);
		if (arst_n && done) sb.check_dist(distance_squared);
	end

	task automatic send_pair(seg_pair_t p);
		for (int i = 0; i < 12; i++) pts[i] <= p[i];
		start <= 1;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 3);
		start <= 0;
		repeat (n) @(posedge clk);
	endtask

	function automatic coord_t rnd_coord(int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($signed($urandom_range(0, 64)) - 32);
			2: return coord_t'($signed($urandom_range(0, 8192)) - 4096);
			default: return ($urandom_range(0, 1)) ? coord_t'({1'b0, {(CW-1){1'b1}}})
				: coord_t'({1'b1, {(CW-1){1'b0}}});
		endcase
	endfunction

	function automatic seg_pair_t rnd_pair();
		seg_pair_t p;
		int mode, kind, k;
		mode = $urandom_range(0, 3);
		for (int i = 0; i < 12; i++) p[i] = rnd_coord(mode);
		kind = $urandom_range(0, 7);
		case (kind)
			0: for (int i = 0; i < 3; i++) p[3+i] = p[i];            // A a point
			1: for (int i = 0; i < 3; i++) p[9+i] = p[6+i];          // B a point
			2: begin                                                 // parallel
				k = $urandom_range(1, 3);
				for (int i = 0; i < 3; i++) begin
					p[i] = rnd_coord(1); p[3+i] = rnd_coord(1); p[6+i] = rnd_coord(1);
					p[9+i] = coord_t'(p[6+i] + k * (p[3+i] - p[i]));
				end
			end
			3: begin                                                 // both points
				for (int i = 0; i < 3; i++) begin
					p[3+i] = p[i]; p[9+i] = p[6+i];
				end
			end
			default: ;
		endcase
		return p;
	endfunction

	function automatic seg_pair_t mk(int v[12]);
		seg_pair_t p;
		for (int i = 0; i < 12; i++) p[i] = coord_t'(v[i]);
		return p;
	endfunction

	initial begin
		int mx, mn;
		mx = (1 << (CW-1)) - 1;
		mn = -(1 << (CW-1));
		repeat (9) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		send_pair(mk('{0,0,0, 0,0,0, 0,0,0, 0,0,0}));
		send_pair(mk('{mx,mx,mx, mx,mx,mx, mn,mn,mn, mn,mn,mn}));
		send_pair(mk('{mn,mn,mn, mx,mx,mx, mx,mn,mx, mn,mx,mn}));
		send_pair(mk('{mx,mn,mx, mn,mx,mn, mn,mn,mn, mx,mx,mx}));
		send_pair(mk('{mn,mn,mn, mn,mn,mn, mx,mx,mx, mx,mx,mx}));
		send_pair(mk('{mx,mx,mx, mn,mn,mn, mx,mx,mx, mn,mn,mn}));
		send_pair(mk('{5,5,5, 5,5,5, 0,0,0, 256,0,0}));             // A a point, t mid
		send_pair(mk('{-900,7,7, -900,7,7, 0,0,0, 256,0,0}));       // A point, t clamps 0
		send_pair(mk('{900,7,7, 900,7,7, 0,0,0, 256,0,0}));         // A point, t clamps 1
		send_pair(mk('{0,0,0, 512,0,0, 100,300,0, 100,300,0}));     // B a point
		send_pair(mk('{0,0,0, 512,0,0, -100,3,0, -100,3,0}));
		send_pair(mk('{0,0,0, 512,0,0, 0,256,0, 512,256,0}));       // parallel
		send_pair(mk('{0,0,0, 512,0,0, 2000,256,0, 3000,256,0}));   // parallel, t clamps 0, s clamps 1
		send_pair(mk('{0,0,0, 512,0,0, -2000,256,0, -900,256,0}));
		send_pair(mk('{0,0,0, 256,0,0, 128,-256,77, 128,256,77}));  // perpendicular, 77 apart in z
		send_pair(mk('{0,0,0, 256,0,0, 4000,-10,5, 9000,10,5}));    // t below
		send_pair(mk('{0,0,0, 256,0,0, 9000,10,5, 4000,-10,5}));    // t above
		send_pair(mk('{3,-7,11, -1,2,9, 13,5,-6, -4,8,1}));
		send_pair(mk('{-1,-1,-1, -1,-1,-1, -1,-1,-1, -1,-1,-1}));
		idle_gap();

		for (int n = 0; n < 550; n++) begin
			send_pair(rnd_pair());
			if (n == 275) begin
				start <= 0;
				@(posedge clk);
				while (sb.pending.size() != 0) @(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				idle_gap();
			end
		end
		start <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LAT + 10) @(posedge clk);

		$display("Covered %0d segment pairs, %0d results: extremes, point segments,",
			sb.n_in, sb.n_out);
		$display("parallel pairs, clamped parameters and random geometry with idle gaps.");
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#5000000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule

// File: sim.f
rtl/ssd_pkg.sv
rtl/ssd_dly.sv
rtl/ssd_mul.sv
rtl/ssd_div.sv
rtl/segment_segment_distance_sq.sv
tb/tb_segment_segment_distance_sq.sv
